@@ rtl/osp_pkg.sv @@
// shared types, codes and sprite size tables for the object sprite pixel fetch
`timescale 1ns / 1ps

package osp_pkg;

	localparam int TILE_BYTES      = 32768;
	localparam int PALETTE_ENTRIES = 256;
	localparam int TILE_AW         = $clog2(TILE_BYTES);
	localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);

	// number of shape/size codes that name a real sprite size
	localparam logic [3:0] SIZE_CODES = 4'd12;

	// configuration register indexes
	localparam logic [1:0] REG_ONE_D_MAPPING = 2'd0;

	typedef enum logic [1:0] {
		OP_TILE_WR = 2'd0,
		OP_PAL_WR  = 2'd1,
		OP_FETCH   = 2'd2
	} op_t;

	// side information of a fetch waiting on the tile read
	typedef struct packed {
		logic       mode256;
		logic       nib_hi;
		logic [3:0] bank;
		logic       shape_ok;
		logic       in_sprite;
	} fetch_info_t;

	// side information of a fetch waiting on the palette read
	typedef struct packed {
		logic shape_ok;
		logic in_sprite;
	} color_info_t;

	function automatic logic [6:0] sprite_width(input logic [3:0] code);
		logic [6:0] w;
		case (code)
			4'd0, 4'd8, 4'd9:         w = 7'd8;
			4'd1, 4'd4, 4'd10:        w = 7'd16;
			4'd2, 4'd5, 4'd6, 4'd11:  w = 7'd32;
			4'd3, 4'd7:               w = 7'd64;
			default:                  w = 7'd0;
		endcase
		return w;
	endfunction

	function automatic logic [6:0] sprite_height(input logic [3:0] code);
		logic [6:0] h;
		case (code)
			4'd0, 4'd4, 4'd5:         h = 7'd8;
			4'd1, 4'd6, 4'd8:         h = 7'd16;
			4'd2, 4'd7, 4'd9, 4'd10:  h = 7'd32;
			4'd3, 4'd11:              h = 7'd64;
			default:                  h = 7'd0;
		endcase
		return h;
	endfunction

endpackage

@@ rtl/obj_sprite_pixel_fetch_top.sv @@
// top level of the object sprite pixel fetch: tile store, palette and fetch pipeline
`timescale 1ns / 1ps

// object sprite pixel fetch
// input channel (in_valid / in_stall): one beat is a tile byte write, a palette
// color write or a pixel fetch; op code 3 is taken and dropped
// writes land in the stores at the edge that takes the beat and make no result
// a fetch decodes the sprite size, forms the tile byte address, reads the tile
// store, then the palette, and gives one result beat on the output channel
// (out_valid / out_stall) with rgb888 color and the shape and bounds flags
// throughput: one beat per cycle while out_stall is low, set by one read per cycle on each ram port
// pipeline: tile read (s1), palette read (s2), output register
// stall: bubbles collapse; in_stall rises only when all three stages are full
// and out_stall holds the output beat
// reset: clears the stage valid bits and one_d_mapping; the stores are not
// cleared and hold whatever they hold until written
// config: apb port, register 0 (one_d_mapping) at byte address 0, pready tied high

module obj_sprite_pixel_fetch_top
	import osp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,

	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [14:0] write_address,
	input  logic [15:0] write_data,
	input  logic [15:0] attr_zero,
	input  logic [15:0] attr_one,
	input  logic [15:0] attr_two,
	input  logic [5:0]  pixel_x,
	input  logic [5:0]  pixel_y,

	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic        shape_valid,
	output logic        inside_res
);

	// configuration register
	logic one_d_q;
	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	// only one register: writes land in it, reads off its address return zero
	assign prdata = (paddr == 2'(REG_ONE_D_MAPPING * 4)) ? {31'd0, one_d_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			one_d_q <= 1'b0;
		end else if (cfg_wr) begin
			one_d_q <= pwdata[0];
		end
	end

	// pipeline flow control, each stage moves when the one below has room
	logic v_s1, v_s2, out_valid_q;
	logic en_s1, en_s2, en_out;
	logic in_take;

	assign en_out  = !out_valid_q || !out_stall;
	assign en_s2   = !v_s2 || en_out;
	assign en_s1   = !v_s1 || en_s2;
	assign in_stall = !en_s1;
	assign in_take = in_valid && !in_stall;

	logic tile_we, pal_we, fetch_take;
	assign tile_we    = in_take && (op == OP_TILE_WR);
	assign pal_we     = in_take && (op == OP_PAL_WR);
	assign fetch_take = in_take && (op == OP_FETCH);

	// sprite decode and tile byte address
	logic [3:0]  size_code;
	logic [6:0]  spr_w, spr_h;
	logic        shape_ok, in_sprite;
	logic        mode256;
	logic [9:0]  tile_eff;
	logic [5:0]  row_inc;
	logic [8:0]  row_off;
	logic [10:0] tile_base;
	logic [15:0] in_tile;
	logic [15:0] addr_full;
	logic [TILE_AW-1:0] fetch_addr;

	always_comb begin
		size_code = {attr_zero[15:14], attr_one[15:14]};
		spr_w     = sprite_width(size_code);
		spr_h     = sprite_height(size_code);
		shape_ok  = size_code < SIZE_CODES;
		in_sprite = shape_ok && ({1'b0, pixel_x} < spr_w) && ({1'b0, pixel_y} < spr_h);
		mode256   = attr_zero[13];

		// 2d 256-color mapping uses even tile numbers only
		tile_eff = (mode256 && !one_d_q) ? {attr_two[9:1], 1'b0} : attr_two[9:0];

		// tiles per sprite row: width in tiles (doubled for 256 colors) or 32
		if (!one_d_q) begin
			row_inc = 6'd32;
		end else if (mode256) begin
			row_inc = spr_w[6:1] >> 1;
		end else begin
			row_inc = spr_w[6:1] >> 2;
		end

		row_off   = {6'd0, pixel_y[5:3]} * {3'd0, row_inc};
		tile_base = {1'b0, tile_eff} + {2'b0, row_off};

		// byte offset inside the tile row: column tile, row, byte in row
		if (mode256) begin
			in_tile = {7'd0, pixel_x[5:3], pixel_y[2:0], pixel_x[2:0]};
		end else begin
			in_tile = {8'd0, pixel_x[5:3], pixel_y[2:0], pixel_x[2:1]};
		end

		addr_full  = {tile_base, 5'd0} + in_tile;
		fetch_addr = addr_full[TILE_AW-1:0];
	end

	// tile store
	logic [7:0] tile_rdata;

	osp_ram #(
		.WIDTH (8),
		.DEPTH (TILE_BYTES)
	) u_tile_ram (
		.clk   (clk),
		.we    (tile_we),
		.waddr (write_address[TILE_AW-1:0]),
		.wdata (write_data[7:0]),
		.re    (fetch_take),
		.raddr (fetch_addr),
		.rdata (tile_rdata)
	);

	// stage 1: tile byte arrives
	fetch_info_t info_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= fetch_take;
		end
	end

	always_ff @(posedge clk) begin
		if (fetch_take) begin
			info_s1.mode256   <= mode256;
			info_s1.nib_hi    <= pixel_x[0];
			info_s1.bank      <= attr_two[15:12];
			info_s1.shape_ok  <= shape_ok;
			info_s1.in_sprite <= in_sprite;
		end
	end

	// palette index: whole byte, or bank and nibble
	logic [PAL_AW-1:0] pal_index;
	logic [3:0]        nib;
	logic              pal_re;

	always_comb begin
		nib       = info_s1.nib_hi ? tile_rdata[7:4] : tile_rdata[3:0];
		pal_index = info_s1.mode256 ? tile_rdata : {info_s1.bank, nib};
	end

	assign pal_re = en_s2 && v_s1;

	logic [15:0] pal_rdata;

	osp_ram #(
		.WIDTH (16),
		.DEPTH (PALETTE_ENTRIES)
	) u_pal_ram (
		.clk   (clk),
		.we    (pal_we),
		.waddr (write_address[PAL_AW-1:0]),
		.wdata (write_data),
		.re    (pal_re),
		.raddr (pal_index),
		.rdata (pal_rdata)
	);

	// stage 2: palette color arrives
	color_info_t info_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (pal_re) begin
			info_s2.shape_ok  <= info_s1.shape_ok;
			info_s2.in_sprite <= info_s1.in_sprite;
		end
	end

	// output register, bgr555 to rgb888, zero outside the sprite
	logic [7:0] red_q, green_q, blue_q;
	logic       shape_valid_q, inside_res_q;
	logic       show;

	assign show = info_s2.shape_ok && info_s2.in_sprite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en_out) begin
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && v_s2) begin
			red_q         <= show ? {pal_rdata[4:0], 3'd0} : 8'd0;
			green_q       <= show ? {pal_rdata[9:5], 3'd0} : 8'd0;
			blue_q        <= show ? {pal_rdata[14:10], 3'd0} : 8'd0;
			shape_valid_q <= info_s2.shape_ok;
			inside_res_q  <= info_s2.in_sprite;
		end
	end

	assign out_valid   = out_valid_q;
	assign red         = red_q;
	assign green       = green_q;
	assign blue        = blue_q;
	assign shape_valid = shape_valid_q;
	assign inside_res  = inside_res_q;

`ifndef NO_ASSERTIONS
	// input only backs up when every stage is full and the output is held
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && v_s2 && out_valid_q && out_stall))
		else $error("input stalled with room in the pipeline");

	// a taken fetch always lands in stage 1
	a_fetch_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && (op == OP_FETCH)) |=> v_s1)
		else $error("fetch beat lost at stage 1");

	// a prohibited shape or an outside pixel gives black and a clear bounds flag
	a_zero_color: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !(shape_valid && inside_res)) |->
		((red == 8'd0) && (green == 8'd0) && (blue == 8'd0) &&
		(shape_valid || !inside_res)))
		else $error("color not cleared outside the sprite");
`endif

endmodule

@@ rtl/osp_ram.sv @@
// generic single-port-write, single-port-read ram with registered read data
`timescale 1ns / 1ps

module osp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read returns the old contents on a same-cycle write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
